@@ sv/isfd_pkg.sv @@
// Shared constants, codes and types of the IMU serial frame decoder.
package isfd_pkg;

    // Frame layout
    localparam int unsigned FRAME_BYTES = 11;
    localparam int unsigned LAST_POS    = FRAME_BYTES - 1;
    localparam int unsigned POS_W       = $clog2(FRAME_BYTES + 1);
    localparam int unsigned BODY_BYTES  = 8;   // bytes 2..9
    localparam int unsigned BODY_W      = 8 * BODY_BYTES;

    localparam logic [7:0] SYNC_BYTE  = 8'h55;
    localparam logic [7:0] TYPE_ACCEL = 8'h51;
    localparam logic [7:0] TYPE_GYRO  = 8'h52;
    localparam logic [7:0] TYPE_ANGLE = 8'h53;
    localparam logic [7:0] TYPE_MAG   = 8'h54;
    localparam logic [7:0] TYPE_PRESS = 8'h56;
    localparam logic [7:0] TYPE_LONLAT = 8'h57;
    localparam logic [7:0] TYPE_GPS   = 8'h58;
    localparam logic [7:0] TYPE_QUAT  = 8'h59;
    localparam logic [7:0] TYPE_GPSACC = 8'h5A;

    // Result status codes
    localparam logic [1:0] STATUS_GOOD = 2'd0;
    localparam logic [1:0] STATUS_CSUM = 2'd1;
    localparam logic [1:0] STATUS_TYPE = 2'd2;

    // Result kind codes
    localparam logic [3:0] KIND_ACCEL  = 4'd0;
    localparam logic [3:0] KIND_GYRO   = 4'd1;
    localparam logic [3:0] KIND_ANGLE  = 4'd2;
    localparam logic [3:0] KIND_MAG    = 4'd3;
    localparam logic [3:0] KIND_PRESS  = 4'd4;
    localparam logic [3:0] KIND_LONLAT = 4'd5;
    localparam logic [3:0] KIND_GPS    = 4'd6;
    localparam logic [3:0] KIND_QUAT   = 4'd7;
    localparam logic [3:0] KIND_GPSACC = 4'd8;

    // Configuration registers
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_FS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_FS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_FS = 2'd2;
    localparam logic [15:0] ACCEL_FS_RST = 16'd16;
    localparam logic [15:0] GYRO_FS_RST  = 16'd2000;
    localparam logic [15:0] ANGLE_FS_RST = 16'd180;

    // Result values
    localparam int unsigned VALUE_W = 40;

    // Degree split: x / 10^7 = (x >> 7) / 78125, estimated by a reciprocal
    // multiply that is at most one low, then fixed by one compare-subtract.
    localparam int unsigned DEG_DIV     = 10000000;
    localparam int unsigned DEG_SHIFT   = 7;
    localparam int unsigned DEG_ODD     = DEG_DIV >> DEG_SHIFT;
    localparam int unsigned RECIP_SHIFT = 32;
    localparam int unsigned RECIP       = 32'((64'd1 << RECIP_SHIFT) / DEG_ODD);
    localparam int unsigned RECIP_W     = 16;
    localparam int unsigned DIVIDEND_W  = 32 - DEG_SHIFT;
    localparam int unsigned RPROD_W     = DIVIDEND_W + RECIP_W;
    localparam int unsigned QUOT_W      = RPROD_W - RECIP_SHIFT;
    localparam int unsigned REM_W       = 25;

    // Scaled product: signed 16-bit word times unsigned 16-bit scale
    localparam int unsigned SPROD_W = 33;

    typedef logic signed [VALUE_W-1:0] t_value;

    typedef struct packed {
        logic [1:0]        status;
        logic [3:0]        kind;
        logic [BODY_W-1:0] body;    // frame byte 2 in bits [7:0]
    } t_frame_rec;

    typedef struct packed {
        logic [15:0] accel_fs;
        logic [15:0] gyro_fs;
        logic [15:0] angle_fs;
    } t_cfg;

endpackage

@@ sv/isfd_if.sv @@
// Channel interfaces: received bytes, decoded results, register writes.
interface isfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface isfd_out_if;
    logic                 valid;
    logic                 ready;
    logic [1:0]           frame_status;
    logic [3:0]           frame_kind;
    isfd_pkg::t_value     value_a;
    isfd_pkg::t_value     value_b;
    isfd_pkg::t_value     value_c;
    isfd_pkg::t_value     value_d;

    modport source (output valid, output frame_status, output frame_kind,
                    output value_a, output value_b, output value_c,
                    output value_d, input ready);
    modport sink   (input valid, input frame_status, input frame_kind,
                    input value_a, input value_b, input value_c,
                    input value_d, output ready);
endinterface

interface isfd_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [isfd_pkg::CFG_IDX_W-1:0]     index;
    logic [15:0]                        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/isfd_collect.sv @@
// Front end: byte collection, checksum and type classification.
module isfd_collect (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    isfd_in_if.sink              i_rx,
    input  logic                 i_q_full,
    output logic                 o_push,
    output isfd_pkg::t_frame_rec o_rec
);

    localparam logic [isfd_pkg::POS_W-1:0] POS_LAST =
        isfd_pkg::POS_W'(isfd_pkg::LAST_POS);
    localparam logic [isfd_pkg::POS_W-1:0] POS_END =
        isfd_pkg::POS_W'(isfd_pkg::FRAME_BYTES);

    logic [isfd_pkg::POS_W-1:0] r_pos, n_pos;
    logic [7:0]                 r_sum, n_sum;
    logic [7:0]                 r_bytes [1:isfd_pkg::LAST_POS-1];

    logic                       accept;
    logic                       lead;
    logic                       active;
    logic [isfd_pkg::POS_W-1:0] pos_eff;
    logic [7:0]                 sum_eff;
    logic [7:0]                 b;

    assign i_rx.ready = !i_q_full;
    assign accept     = i_rx.valid && i_rx.ready;
    assign b          = i_rx.rx_byte;
    assign lead       = (b == isfd_pkg::SYNC_BYTE);
    assign pos_eff    = lead ? '0 : r_pos;
    assign sum_eff    = lead ? '0 : r_sum;
    assign active     = (pos_eff < POS_END);

    always_comb begin
        n_pos = r_pos;
        n_sum = r_sum;
        if (accept) begin
            n_pos = active ? pos_eff + 1'b1 : pos_eff;
            n_sum = (active && pos_eff < POS_LAST) ? sum_eff + b : sum_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_sum <= '0;
        end else begin
            r_pos <= n_pos;
            r_sum <= n_sum;
        end
    end

    // Byte 0 only feeds the sum; byte 10 is compared as it arrives
    always_ff @(posedge i_clk) begin
        if (accept && active && pos_eff != '0 && pos_eff < POS_LAST) begin
            r_bytes[pos_eff] <= b;
        end
    end

    assign o_push = accept && active && (pos_eff == POS_LAST);

    always_comb begin
        o_rec.status = isfd_pkg::STATUS_GOOD;
        o_rec.kind   = isfd_pkg::KIND_ACCEL;
        unique case (r_bytes[1])
            isfd_pkg::TYPE_ACCEL:  o_rec.kind = isfd_pkg::KIND_ACCEL;
            isfd_pkg::TYPE_GYRO:   o_rec.kind = isfd_pkg::KIND_GYRO;
            isfd_pkg::TYPE_ANGLE:  o_rec.kind = isfd_pkg::KIND_ANGLE;
            isfd_pkg::TYPE_MAG:    o_rec.kind = isfd_pkg::KIND_MAG;
            isfd_pkg::TYPE_PRESS:  o_rec.kind = isfd_pkg::KIND_PRESS;
            isfd_pkg::TYPE_LONLAT: o_rec.kind = isfd_pkg::KIND_LONLAT;
            isfd_pkg::TYPE_GPS:    o_rec.kind = isfd_pkg::KIND_GPS;
            isfd_pkg::TYPE_QUAT:   o_rec.kind = isfd_pkg::KIND_QUAT;
            isfd_pkg::TYPE_GPSACC: o_rec.kind = isfd_pkg::KIND_GPSACC;
            default:               o_rec.status = isfd_pkg::STATUS_TYPE;
        endcase
        if (o_rec.status == isfd_pkg::STATUS_GOOD && sum_eff != b) begin
            o_rec.status = isfd_pkg::STATUS_CSUM;
        end
        o_rec.body = {r_bytes[9], r_bytes[8], r_bytes[7], r_bytes[6],
                      r_bytes[5], r_bytes[4], r_bytes[3], r_bytes[2]};
    end

endmodule

@@ sv/isfd_queue.sv @@
// Two-entry frame queue between collector and decoder.
module isfd_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  isfd_pkg::t_frame_rec i_rec,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_valid,
    output isfd_pkg::t_frame_rec o_rec
);

    logic                 r_head_v, r_tail_v;
    isfd_pkg::t_frame_rec r_head, r_tail;
    logic                 pop;

    assign pop     = i_pop && r_head_v;
    assign o_full  = r_tail_v;
    assign o_valid = r_head_v;
    assign o_rec   = r_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_v <= 1'b0;
            r_tail_v <= 1'b0;
        end else begin
            if (pop) begin
                if (r_tail_v) begin
                    r_head   <= r_tail;
                    r_tail_v <= i_push;
                    r_tail   <= i_rec;
                end else begin
                    r_head_v <= i_push;
                    r_head   <= i_rec;
                end
            end else if (i_push) begin
                if (!r_head_v) begin
                    r_head_v <= 1'b1;
                    r_head   <= i_rec;
                end else begin
                    r_tail_v <= 1'b1;
                    r_tail   <= i_rec;
                end
            end
        end
    end

endmodule

@@ sv/isfd_decode.sv @@
// Back end: three-stage value decode with registered result.
module isfd_decode (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  isfd_pkg::t_cfg       i_cfg,
    input  logic                 i_valid,
    input  isfd_pkg::t_frame_rec i_rec,
    output logic                 o_pop,
    isfd_out_if.source           o_res
);

    localparam logic [1:0] SEL_PLAIN  = 2'd0;
    localparam logic [1:0] SEL_SCALED = 2'd1;
    localparam logic [1:0] SEL_LONLAT = 2'd2;
    localparam logic [31:0] DIV_C = 32'(isfd_pkg::DEG_DIV);
    localparam logic [isfd_pkg::RPROD_W-1:0] RECIP_C =
        isfd_pkg::RPROD_W'(isfd_pkg::RECIP);

    logic en;

    // Stage 1: word select and products
    logic [15:0]               w [4];
    logic [15:0]               n1_scale;
    logic [1:0]                n1_sel;
    isfd_pkg::t_value          n1_plain [4];
    logic [31:0]               lon, lat;

    logic                      r1_valid;
    logic [1:0]                r1_status, r1_sel;
    logic [3:0]                r1_kind;
    isfd_pkg::t_value          r1_plain [4];
    logic signed [isfd_pkg::SPROD_W-1:0] r1_prod [3];
    logic [isfd_pkg::RPROD_W-1:0] r1_rlon, r1_rlat;
    logic [31:0]               r1_lon, r1_lat;

    // Stage 2: value select, quotient back-multiply
    isfd_pkg::t_value          n2_v [4];
    logic [isfd_pkg::QUOT_W-1:0] q1_lon, q1_lat;

    logic                      r2_valid, r2_lonlat;
    logic [1:0]                r2_status;
    logic [3:0]                r2_kind;
    isfd_pkg::t_value          r2_v [4];
    logic [isfd_pkg::QUOT_W-1:0] r2_qlon, r2_qlat;
    logic [31:0]               r2_plon, r2_plat, r2_lon, r2_lat;

    // Output stage: quotient correction
    logic [31:0]               rem_lon, rem_lat;
    logic [isfd_pkg::QUOT_W-1:0] fq_lon, fq_lat;
    logic [isfd_pkg::REM_W-1:0]  fr_lon, fr_lat;

    logic                      r_out_valid;

    assign en    = !r_out_valid || o_res.ready;
    assign o_pop = en;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w[k] = i_rec.body[16*k +: 16];
        end
    end
    assign lon = i_rec.body[31:0];
    assign lat = i_rec.body[63:32];

    always_comb begin
        n1_scale = '0;
        n1_sel   = SEL_PLAIN;
        for (int k = 0; k < 4; k++) begin
            n1_plain[k] = '0;
        end
        if (i_rec.status == isfd_pkg::STATUS_GOOD) begin
            unique case (i_rec.kind)
                isfd_pkg::KIND_ACCEL: begin
                    n1_scale    = i_cfg.accel_fs;
                    n1_sel      = SEL_SCALED;
                    n1_plain[3] = {{24{w[3][15]}}, w[3]};
                end
                isfd_pkg::KIND_GYRO: begin
                    n1_scale = i_cfg.gyro_fs;
                    n1_sel   = SEL_SCALED;
                end
                isfd_pkg::KIND_ANGLE: begin
                    n1_scale    = i_cfg.angle_fs;
                    n1_sel      = SEL_SCALED;
                    n1_plain[3] = {24'b0, w[3]};
                end
                isfd_pkg::KIND_MAG: begin
                    for (int k = 0; k < 3; k++) begin
                        n1_plain[k] = {{24{w[k][15]}}, w[k]};
                    end
                end
                isfd_pkg::KIND_PRESS: begin
                    n1_plain[0] = {8'b0, lon};
                    n1_plain[1] = {8'b0, lat};
                end
                isfd_pkg::KIND_LONLAT: begin
                    n1_sel = SEL_LONLAT;
                end
                isfd_pkg::KIND_GPS: begin
                    n1_plain[0] = {24'b0, w[0]};
                    n1_plain[1] = {24'b0, w[1]};
                    n1_plain[2] = {8'b0, lat};
                end
                isfd_pkg::KIND_QUAT: begin
                    for (int k = 0; k < 4; k++) begin
                        n1_plain[k] = {{24{w[k][15]}}, w[k]};
                    end
                end
                default: begin
                    for (int k = 0; k < 4; k++) begin
                        n1_plain[k] = {24'b0, w[k]};
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_status <= i_rec.status;
            r1_kind   <= i_rec.kind;
            r1_sel    <= n1_sel;
            r1_plain  <= n1_plain;
            r1_lon    <= lon;
            r1_lat    <= lat;
            for (int k = 0; k < 3; k++) begin
                r1_prod[k] <= $signed({{17{w[k][15]}}, w[k]})
                            * $signed({17'b0, n1_scale});
            end
            r1_rlon <= isfd_pkg::RPROD_W'(lon[31:isfd_pkg::DEG_SHIFT]) * RECIP_C;
            r1_rlat <= isfd_pkg::RPROD_W'(lat[31:isfd_pkg::DEG_SHIFT]) * RECIP_C;
        end
    end

    assign q1_lon = r1_rlon[isfd_pkg::RECIP_SHIFT +: isfd_pkg::QUOT_W];
    assign q1_lat = r1_rlat[isfd_pkg::RECIP_SHIFT +: isfd_pkg::QUOT_W];

    always_comb begin
        n2_v = r1_plain;
        if (r1_sel == SEL_SCALED) begin
            for (int k = 0; k < 3; k++) begin
                n2_v[k] = {{(isfd_pkg::VALUE_W - isfd_pkg::SPROD_W)
                            {r1_prod[k][isfd_pkg::SPROD_W-1]}}, r1_prod[k]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_status <= r1_status;
            r2_kind   <= r1_kind;
            r2_lonlat <= (r1_sel == SEL_LONLAT);
            r2_v      <= n2_v;
            r2_qlon   <= q1_lon;
            r2_qlat   <= q1_lat;
            r2_plon   <= 32'(q1_lon) * DIV_C;
            r2_plat   <= 32'(q1_lat) * DIV_C;
            r2_lon    <= r1_lon;
            r2_lat    <= r1_lat;
        end
    end

    // Estimate is exact or one low; remainder then lies below twice the divisor
    assign rem_lon = r2_lon - r2_plon;
    assign rem_lat = r2_lat - r2_plat;

    always_comb begin
        fq_lon = r2_qlon;
        fr_lon = rem_lon[isfd_pkg::REM_W-1:0];
        if (rem_lon >= DIV_C) begin
            fq_lon = r2_qlon + 1'b1;
            fr_lon = isfd_pkg::REM_W'(rem_lon - DIV_C);
        end
        fq_lat = r2_qlat;
        fr_lat = rem_lat[isfd_pkg::REM_W-1:0];
        if (rem_lat >= DIV_C) begin
            fq_lat = r2_qlat + 1'b1;
            fr_lat = isfd_pkg::REM_W'(rem_lat - DIV_C);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_res.frame_status <= r2_status;
            o_res.frame_kind   <= r2_kind;
            if (r2_lonlat) begin
                o_res.value_a <= isfd_pkg::VALUE_W'(fq_lon);
                o_res.value_b <= isfd_pkg::VALUE_W'(fr_lon);
                o_res.value_c <= isfd_pkg::VALUE_W'(fq_lat);
                o_res.value_d <= isfd_pkg::VALUE_W'(fr_lat);
            end else begin
                o_res.value_a <= r2_v[0];
                o_res.value_b <= r2_v[1];
                o_res.value_c <= r2_v[2];
                o_res.value_d <= r2_v[3];
            end
        end
    end

    assign o_res.valid = r_out_valid;

endmodule

@@ sv/imu_serial_frame_decoder_core.sv @@
// Top level: 11-byte IMU serial frame decoder with full-scale registers.
// Throughput: one byte per clock; bytes stall only once both queue entries are held,
// and a result that is not taken stalls the whole decode pipe.
// Result path: the frame's last byte transaction writes the frame into the queue, and it
// then passes the product, back-multiply and output stages before the result is valid.
// Reset: synchronous on i_rst_n low; empty collector, queue and pipe; scales 16, 2000, 180.
module imu_serial_frame_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    isfd_in_if.sink     i_rx,
    isfd_cfg_if.sink    i_cfg,
    isfd_out_if.source  o_res
);

    // Full-scale registers; writes are always taken, unknown indexes dropped
    isfd_pkg::t_cfg       r_cfg;

    // Collector to queue
    logic                 push;
    isfd_pkg::t_frame_rec push_rec;
    logic                 q_full;

    // Queue to decoder
    logic                 q_valid;
    logic                 q_pop;
    isfd_pkg::t_frame_rec q_rec;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.accel_fs <= isfd_pkg::ACCEL_FS_RST;
            r_cfg.gyro_fs  <= isfd_pkg::GYRO_FS_RST;
            r_cfg.angle_fs <= isfd_pkg::ANGLE_FS_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                isfd_pkg::REG_ACCEL_FS: r_cfg.accel_fs <= i_cfg.data;
                isfd_pkg::REG_GYRO_FS:  r_cfg.gyro_fs  <= i_cfg.data;
                isfd_pkg::REG_ANGLE_FS: r_cfg.angle_fs <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Front: takes bytes, tracks position and checksum, classifies the type
    isfd_collect u_collect (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rx     (i_rx),
        .i_q_full (q_full),
        .o_push   (push),
        .o_rec    (push_rec)
    );

    // Completed frames wait here so either side can stall alone
    isfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_rec   (q_rec)
    );

    // Back: scaling products, degree/minute split, result register
    isfd_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (q_valid),
        .i_rec   (q_rec),
        .o_pop   (q_pop),
        .o_res   (o_res)
    );

endmodule

@@ bench/tb_imu_serial_frame_decoder_core.sv @@
// Self-checking testbench for the IMU serial frame decoder core.
module tb_imu_serial_frame_decoder_core;
    timeunit 1ns;
    timeprecision 1ps;

    typedef isfd_pkg::t_value t_value;

    // ------------------------------------------------------------------
    // Bench constants
    // ------------------------------------------------------------------
    localparam int unsigned FRAME_LEN      = 11;
    localparam int unsigned DEGREE_UNITS   = 10000000;  // raw lon/lat per degree
    localparam int unsigned PHASE_BYTES    = 100;       // counted bytes per phase
    localparam int unsigned SETTLE_CYCLES  = 8;         // pipe is three stages deep
    localparam int unsigned HOLD_CYCLES    = 400;       // long receiver hold-off
    localparam int unsigned WATCHDOG_LIMIT = 4000;      // quiet cycles before abort
    localparam int unsigned REPORT_LIMIT   = 10;
    localparam logic [isfd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3; // no register behind it

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] kind;
        t_value     value_a;
        t_value     value_b;
        t_value     value_c;
        t_value     value_d;
    } t_frame_result;

    // ------------------------------------------------------------------
    // Clock, reset, channels, block under test
    // ------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n;

    always #1 i_clk = ~i_clk;

    isfd_in_if  rx_if ();
    isfd_cfg_if cfg_if ();
    isfd_out_if res_if ();

    imu_serial_frame_decoder_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    // Predicted collector and full-scale registers, advanced per transaction.
    logic [7:0]  frame_store [FRAME_LEN];
    int unsigned collect_pos;
    logic [7:0]  collect_sum;
    logic [15:0] fs_accel;
    logic [15:0] fs_gyro;
    logic [15:0] fs_angle;

    t_frame_result awaited_results [$];   // decoded frames not yet seen at the output
    logic [7:0]    tx_bytes [$];          // bytes still to be offered
    int unsigned   bytes_queued;
    int unsigned   bytes_taken;

    t_frame_result got_result;
    t_frame_result want_result;

    bit          stim_go;
    bit          rx_fire;     // byte transaction at the last rising edge
    bit          cfg_fire;    // register write transaction at the last rising edge
    bit          rx_steady;   // sender offers back to back
    bit          res_steady;  // receiver never stalls
    bit          res_hold_req;
    int unsigned gap_left;
    int unsigned stall_left;
    int unsigned hold_left;
    int unsigned idle_cycles;
    int unsigned fail_count;

    // ------------------------------------------------------------------
    // Frame decode prediction
    // ------------------------------------------------------------------
    // Words are little-endian in the frame store.
    function automatic logic [15:0] word16(int unsigned i);
        return {frame_store[i+1], frame_store[i]};
    endfunction

    function automatic logic [31:0] word32(int unsigned i);
        return {word16(i + 2), word16(i)};
    endfunction

    function automatic longint sword(int unsigned i);
        return longint'($signed(word16(i)));
    endfunction

    // Result of the frame now complete in frame_store, under current scales.
    function automatic t_frame_result decode_frame();
        t_frame_result r;
        logic [15:0]   scale;
        bit            scaled;
        r      = '0;
        scale  = '0;
        scaled = 1'b0;
        case (frame_store[1])
            isfd_pkg::TYPE_ACCEL:  r.kind = isfd_pkg::KIND_ACCEL;
            isfd_pkg::TYPE_GYRO:   r.kind = isfd_pkg::KIND_GYRO;
            isfd_pkg::TYPE_ANGLE:  r.kind = isfd_pkg::KIND_ANGLE;
            isfd_pkg::TYPE_MAG:    r.kind = isfd_pkg::KIND_MAG;
            isfd_pkg::TYPE_PRESS:  r.kind = isfd_pkg::KIND_PRESS;
            isfd_pkg::TYPE_LONLAT: r.kind = isfd_pkg::KIND_LONLAT;
            isfd_pkg::TYPE_GPS:    r.kind = isfd_pkg::KIND_GPS;
            isfd_pkg::TYPE_QUAT:   r.kind = isfd_pkg::KIND_QUAT;
            isfd_pkg::TYPE_GPSACC: r.kind = isfd_pkg::KIND_GPSACC;
            default:     r.status = isfd_pkg::STATUS_TYPE;   // kind stays zero, sum not looked at
        endcase
        if (r.status == isfd_pkg::STATUS_GOOD && collect_sum != frame_store[10])
            r.status = isfd_pkg::STATUS_CSUM;
        if (r.status != isfd_pkg::STATUS_GOOD)
            return r;
        case (r.kind)
            isfd_pkg::KIND_ACCEL: begin
                scale     = fs_accel;
                scaled    = 1'b1;
                r.value_d = t_value'(sword(8));        // temperature, signed
            end
            isfd_pkg::KIND_GYRO: begin
                scale  = fs_gyro;
                scaled = 1'b1;
            end
            isfd_pkg::KIND_ANGLE: begin
                scale     = fs_angle;
                scaled    = 1'b1;
                r.value_d = t_value'(word16(8));       // version, unsigned
            end
            isfd_pkg::KIND_MAG: begin
                r.value_a = t_value'(sword(2));
                r.value_b = t_value'(sword(4));
                r.value_c = t_value'(sword(6));
            end
            isfd_pkg::KIND_PRESS: begin
                r.value_a = t_value'(word32(2));
                r.value_b = t_value'(word32(6));
            end
            isfd_pkg::KIND_LONLAT: begin
                r.value_a = t_value'(word32(2) / DEGREE_UNITS);
                r.value_b = t_value'(word32(2) % DEGREE_UNITS);
                r.value_c = t_value'(word32(6) / DEGREE_UNITS);
                r.value_d = t_value'(word32(6) % DEGREE_UNITS);
            end
            isfd_pkg::KIND_GPS: begin
                r.value_a = t_value'(word16(2));
                r.value_b = t_value'(word16(4));
                r.value_c = t_value'(word32(6));
            end
            isfd_pkg::KIND_QUAT: begin
                r.value_a = t_value'(sword(2));
                r.value_b = t_value'(sword(4));
                r.value_c = t_value'(sword(6));
                r.value_d = t_value'(sword(8));
            end
            default: begin                             // gps accuracy
                r.value_a = t_value'(word16(2));
                r.value_b = t_value'(word16(4));
                r.value_c = t_value'(word16(6));
                r.value_d = t_value'(word16(8));
            end
        endcase
        // Signed raw word times unsigned full scale; zero scale gives zero.
        if (scaled) begin
            r.value_a = t_value'(sword(2) * longint'(scale));
            r.value_b = t_value'(sword(4) * longint'(scale));
            r.value_c = t_value'(sword(6) * longint'(scale));
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Payload byte with a bias towards word extremes; never the lead byte.
    function automatic logic [7:0] rand_data_byte();
        logic [7:0] v;
        case ($urandom_range(0, 9))
            0:       v = 8'h00;
            1:       v = 8'hFF;
            2:       v = 8'h80;
            3:       v = 8'h7F;
            default: v = 8'($urandom_range(0, 255));
        endcase
        if (v == isfd_pkg::SYNC_BYTE)
            v = 8'h54;
        return v;
    endfunction

    function automatic logic [63:0] rand_body();
        logic [63:0] w;
        for (int i = 0; i < 8; i++)
            w[8*i +: 8] = rand_data_byte();
        return w;
    endfunction

    function automatic logic [7:0] known_type(int unsigned n);
        case (n % 9)
            0:       return isfd_pkg::TYPE_ACCEL;
            1:       return isfd_pkg::TYPE_GYRO;
            2:       return isfd_pkg::TYPE_ANGLE;
            3:       return isfd_pkg::TYPE_MAG;
            4:       return isfd_pkg::TYPE_PRESS;
            5:       return isfd_pkg::TYPE_LONLAT;
            6:       return isfd_pkg::TYPE_GPS;
            7:       return isfd_pkg::TYPE_QUAT;
            default: return isfd_pkg::TYPE_GPSACC;
        endcase
    endfunction

    // Type bytes mostly outside the table; the lead byte itself restarts collection.
    function automatic logic [7:0] odd_type();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'h50;
            2:       return 8'h5B;
            3:       return 8'hFF;
            4:       return isfd_pkg::SYNC_BYTE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic push_byte(input logic [7:0] b);
        tx_bytes.push_back(b);
        bytes_queued++;
    endtask

    // Eleven bytes: first, type, body (byte 2 in bits 7:0), checksum.
    task automatic queue_frame(input logic [7:0] first, input logic [7:0] kind_byte,
                               input logic [63:0] body, input bit bad_sum);
        logic [7:0] sum;
        logic [7:0] csum;
        sum = first + kind_byte;
        for (int i = 0; i < 8; i++)
            sum += body[8*i +: 8];
        if (bad_sum) begin
            csum = sum + 8'($urandom_range(1, 255));
        end else if (sum == isfd_pkg::SYNC_BYTE) begin
            // A lead byte as checksum would restart the frame; nudge the body.
            body[7:0] = body[7:0] + 8'd1;
            csum      = sum + 8'd1;
        end else begin
            csum = sum;
        end
        push_byte(first);
        push_byte(kind_byte);
        for (int i = 0; i < 8; i++)
            push_byte(body[8*i +: 8]);
        push_byte(csum);
    endtask

    // Random traffic: mostly clean frames cycling through every kind, mixed
    // with bad sums, odd types, cut-short frames and loose noise.
    task automatic queue_traffic(input int unsigned target);
        int unsigned counted;
        int unsigned n;
        int unsigned k;
        int unsigned r;
        counted = 0;
        n       = $urandom_range(0, 8);
        while (counted < target) begin
            r = $urandom_range(0, 99);
            if (r < 72) begin
                queue_frame(isfd_pkg::SYNC_BYTE, known_type(n), rand_body(), 1'b0);
                n++;
                counted += FRAME_LEN;
                // Trailing bytes after a finished frame are dropped by the block.
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(1, 3)) push_byte(rand_data_byte());
            end else if (r < 82) begin
                queue_frame(isfd_pkg::SYNC_BYTE, known_type($urandom_range(0, 8)),
                            rand_body(), 1'b1);
                counted += FRAME_LEN;
            end else if (r < 88) begin
                queue_frame(isfd_pkg::SYNC_BYTE, odd_type(), rand_body(), 1'b0);
                counted += FRAME_LEN;
            end else if (r < 94) begin
                k = $urandom_range(0, 8);
                push_byte(isfd_pkg::SYNC_BYTE);
                push_byte(known_type($urandom_range(0, 8)));
                repeat (k) push_byte(rand_data_byte());
                counted += k + 2;
            end else begin
                repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Register write over the configuration channel; the predictor copy is
    // updated by the monitor on the transaction itself.
    task automatic write_reg(input logic [isfd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] val);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(negedge i_clk); while (!cfg_fire);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic write_scales(input logic [15:0] a, input logic [15:0] g,
                                input logic [15:0] an);
        write_reg(isfd_pkg::REG_ACCEL_FS, a);
        write_reg(isfd_pkg::REG_GYRO_FS, g);
        write_reg(isfd_pkg::REG_ANGLE_FS, an);
    endtask

    // Idle point: every byte taken, every result back, then let a trailing
    // partial frame settle before touching registers or ending.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (bytes_taken != bytes_queued || awaited_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Byte driver: changes on the falling edge, holds until taken
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (stim_go && (!rx_if.valid || rx_fire)) begin
            if (gap_left > 0) begin
                gap_left--;
                rx_if.valid <= 1'b0;
            end else if (tx_bytes.size() > 0) begin
                rx_if.valid   <= 1'b1;
                rx_if.rx_byte <= tx_bytes.pop_front();
                gap_left = rx_steady ? 0 : pick_gap();
            end else begin
                rx_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random stalls, plus one long hold-off on request so
    // that the decode queue fills and the byte input backs up.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (res_hold_req) begin
            hold_left    = HOLD_CYCLES;
            res_hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            res_if.ready <= 1'b0;
        end else begin
            if (!res_steady && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
            res_if.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: samples every channel on the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        rx_fire  <= i_rst_n && rx_if.valid && rx_if.ready;
        cfg_fire <= i_rst_n && cfg_if.valid && cfg_if.ready;
        if (i_rst_n) begin
            // Result transaction: compare with the oldest decoded frame.
            if (res_if.valid && res_if.ready) begin
                got_result.status  = res_if.frame_status;
                got_result.kind    = res_if.frame_kind;
                got_result.value_a = res_if.value_a;
                got_result.value_b = res_if.value_b;
                got_result.value_c = res_if.value_c;
                got_result.value_d = res_if.value_d;
                if (awaited_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: result with no frame awaiting it: status %0d kind %0d",
                                 $realtime, got_result.status, got_result.kind);
                end else begin
                    want_result = awaited_results.pop_front();
                    if (got_result !== want_result) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT) begin
                            $display("%0t: frame result mismatch", $realtime);
                            $display("  exp status %0d kind %0d a %0d b %0d c %0d d %0d",
                                     want_result.status, want_result.kind,
                                     want_result.value_a, want_result.value_b,
                                     want_result.value_c, want_result.value_d);
                            $display("  got status %0d kind %0d a %0d b %0d c %0d d %0d",
                                     got_result.status, got_result.kind,
                                     got_result.value_a, got_result.value_b,
                                     got_result.value_c, got_result.value_d);
                        end
                    end
                end
            end

            // Register write; the unused index changes nothing.
            if (cfg_if.valid && cfg_if.ready) begin
                case (cfg_if.index)
                    isfd_pkg::REG_ACCEL_FS: fs_accel = cfg_if.data;
                    isfd_pkg::REG_GYRO_FS:  fs_gyro  = cfg_if.data;
                    isfd_pkg::REG_ANGLE_FS: fs_angle = cfg_if.data;
                    default: ;
                endcase
            end

            // Byte transaction: lead byte restarts, bytes past a full frame drop.
            if (rx_if.valid && rx_if.ready) begin
                bytes_taken++;
                if (rx_if.rx_byte == isfd_pkg::SYNC_BYTE) begin
                    collect_pos = 0;
                    collect_sum = '0;
                end
                if (collect_pos < FRAME_LEN) begin
                    frame_store[collect_pos] = rx_if.rx_byte;
                    if (collect_pos < FRAME_LEN - 1)
                        collect_sum += rx_if.rx_byte;
                    collect_pos++;
                    if (collect_pos == FRAME_LEN)
                        awaited_results.push_back(decode_frame());
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without any transaction ends the run
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $realtime, idle_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed frames, then one phase per scale setting
    // ------------------------------------------------------------------
    initial begin
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        cfg_if.valid  = 1'b0;
        cfg_if.index  = '0;
        cfg_if.data   = '0;
        res_if.ready  = 1'b0;
        i_rst_n       = 1'b0;
        fs_accel      = isfd_pkg::ACCEL_FS_RST;
        fs_gyro       = isfd_pkg::GYRO_FS_RST;
        fs_angle      = isfd_pkg::ANGLE_FS_RST;
        collect_pos   = 0;
        collect_sum   = '0;
        for (int i = 0; i < FRAME_LEN; i++)
            frame_store[i] = '0;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        stim_go  = 1'b1;

        // Directed: a stream that opens without a lead byte (first byte goes
        // into the sum as stored), accel word extremes, bytes after a complete
        // frame that must be dropped, and a frame with an unknown type byte.
        queue_frame(8'hAA, isfd_pkg::TYPE_ACCEL, 64'h8000_FFFF_7FFF_8000, 1'b0);
        push_byte(8'h00);
        push_byte(8'hFF);
        queue_frame(isfd_pkg::SYNC_BYTE, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        wait_drained();

        // Phases: reset scales, all-ones, minimum with the unused index, zero
        // scales, then random scales (the first of those under back-pressure).
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: ;
                1: write_scales(16'hFFFF, 16'hFFFF, 16'hFFFF);
                2: begin
                    write_scales(16'd1, 16'd1, 16'd1);
                    write_reg(REG_UNUSED, 16'hA5A5);
                end
                3: write_scales(16'd0, 16'd0, 16'd0);
                default: write_scales(16'($urandom_range(1, 65535)),
                                      16'($urandom_range(1, 65535)),
                                      16'($urandom_range(1, 65535)));
            endcase
            rx_steady  = (ph == 1) || (ph == 4);
            res_steady = (ph == 2);
            if (ph == 4) begin
                // Receiver holds off while the sender keeps pushing bytes.
                @(posedge i_clk);
                res_hold_req = 1'b1;
            end
            queue_traffic(PHASE_BYTES);
            wait_drained();
        end

        if (awaited_results.size() != 0) begin
            fail_count += awaited_results.size();
            $display("%0d decoded frames never came out", awaited_results.size());
        end
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
